### rtl/lfc_pkg.sv
// Package for the LIN frame checker: shared types, codes and the protected
// identifier function. No dependencies; lfc_csr and the core import it.

package lfc_pkg;

   // Register index, taken from byte address bit 2.
   typedef enum logic {
      REG_CHECKSUM_MODEL = 1'b0,
      REG_FRAME_ID       = 1'b1
   } reg_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_ECHO_ERROR   = 2'd1,
      STATUS_CHECKSUM_ERR = 2'd2,
      STATUS_LENGTH_ERROR = 2'd3
   } status_type;

   // Checksum models.
   localparam logic MODEL_CLASSIC  = 1'b0;
   localparam logic MODEL_ENHANCED = 1'b1;

   // Diagnostic protected identifiers that always use the classic checksum.
   localparam logic [7:0] PID_MASTER_REQUEST = 8'h3C;
   localparam logic [7:0] PID_SLAVE_RESPONSE = 8'h7D;

   // Frame positions: break, sync and PID come first, data starts at 3.
   localparam logic [3:0] FIRST_DATA_POS = 4'd3;
   localparam logic [3:0] LAST_POS       = 4'd15;

   localparam int APB_DATA_WIDTH = 32;
   localparam int APB_ADDR_WIDTH = 3;

   // Configuration as seen by the checking logic.
   typedef struct packed {
      logic       checksum_model;
      logic [7:0] frame_id;
   } cfg_type;

   // Identifier bits 5..0 with P0 at bit 6 and inverted P1 at bit 7.
   function automatic logic [7:0] make_pid(input logic [7:0] frame_id);
      logic [5:0] id;
      logic       p0;
      logic       p1;
      id = frame_id[5:0];
      p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
      p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
      return {p1, p0, id};
   endfunction

endpackage

### rtl/lfc_if.sv
// Handshake interfaces for the LIN frame checker's byte and result channels.
// Depends on nothing but the port widths of the frame checker.

interface lfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [7:0] tx_byte;
   logic       echo_check;
   logic       last_byte;

   modport source (output valid, rx_byte, tx_byte, echo_check, last_byte, input ready);
   modport sink   (input valid, rx_byte, tx_byte, echo_check, last_byte, output ready);
endinterface

interface lfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [7:0] protected_id;
   logic [7:0] expected_checksum;

   modport source (output valid, status, protected_id, expected_checksum, input ready);
   modport sink   (input valid, status, protected_id, expected_checksum, output ready);
endinterface

### rtl/lfc_csr.sv
// Configuration registers of the LIN frame checker behind an APB-style port.
// Depends on lfc_pkg for the register indexes and the configuration struct.

module lfc_csr
   import lfc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [APB_ADDR_WIDTH-1:0] paddr,
   input  logic [APB_DATA_WIDTH-1:0] pwdata,
   output logic [APB_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic          model_ff;
   logic          model_in;
   logic [7:0]    frame_id_ff;
   logic [7:0]    frame_id_in;
   logic          wr_en;
   reg_index_type reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = reg_index_type'(paddr[2]);

   always_comb begin
      model_in    = model_ff;
      frame_id_in = frame_id_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_CHECKSUM_MODEL: model_in    = pwdata[0];
            REG_FRAME_ID:       frame_id_in = pwdata[7:0];
            default:            model_in    = model_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         model_ff    <= MODEL_ENHANCED;
         frame_id_ff <= 8'h00;
      end else begin
         model_ff    <= model_in;
         frame_id_ff <= frame_id_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_CHECKSUM_MODEL: prdata = {{(APB_DATA_WIDTH-1){1'b0}}, model_ff};
         REG_FRAME_ID:       prdata = {{(APB_DATA_WIDTH-8){1'b0}}, frame_id_ff};
         default:            prdata = '0;
      endcase
   end

   assign cfg.checksum_model = model_ff;
   assign cfg.frame_id       = frame_id_ff;

endmodule

### rtl/lin_frame_checker_core.sv
// LIN frame checker top level: frame state, checksum and result register.
// Depends on lfc_pkg, the interfaces in lfc_if and the lfc_csr register file.
//
// Usage: the receive path hands the checker one word per frame byte on
// req_chan: the byte read back from the bus, the byte the master sent, a flag
// that asks for an echo comparison, and a flag that marks the checksum byte,
// which ends the frame. Bytes are break, sync, protected identifier, data and
// checksum, in that order. Only the checksum byte produces a result word on
// rsp_chan, carrying the frame status, the protected identifier formed from
// the configured frame_id, and the checksum the frame should have carried.
// Each accepted byte is folded into the frame state in the cycle it is
// accepted, so a result word appears in the cycle after its checksum byte is
// accepted. The block takes one byte per cycle; the only thing that limits
// it is the single result register, which holds a word until rsp_chan takes
// it. While that word is stalled, req_chan.ready is low; once it is taken,
// the next byte can be accepted in the same cycle. The checksum mode and the
// frame identifier are to be written over the APB port between frames; the
// block itself does not enforce this. The enhanced seed is sampled at the
// break byte of each frame, while the reported identifier uses the registers
// at the checksum byte. Reset empties the result register, clears the frame
// state and loads enhanced mode with frame_id zero.

module lin_frame_checker_core
   import lfc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 12
)
(
   input  logic                      clock,
   input  logic                      reset,
   lfc_req_if.sink                   req_chan,
   lfc_rsp_if.source                 rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [APB_ADDR_WIDTH-1:0] paddr,
   input  logic [APB_DATA_WIDTH-1:0] pwdata,
   output logic [APB_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   // Frame length limit in a width that also holds the position plus two.
   localparam logic [4:0] MaxBytes = 5'(MAX_FRAME_BYTES);

   cfg_type    cfg;

   // Frame state.
   logic [3:0] pos_ff;
   logic [3:0] pos_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic       echo_failed_ff;
   logic       echo_failed_in;
   logic       overrun_ff;
   logic       overrun_in;

   // Result register.
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   status_type status_ff;
   status_type status_in;
   logic [7:0] pid_ff;
   logic [7:0] pid_in;
   logic [7:0] expect_ff;
   logic [7:0] expect_in;

   logic       accept;
   logic [7:0] pid_now;
   logic [7:0] seed;
   logic [7:0] sum_cur;
   logic [8:0] sum_wide;
   logic [7:0] sum_wrapped;
   logic       echo_now;
   logic [4:0] pos_wide;
   logic       length_bad;

   lfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The result register is the only buffer: a new byte can come in whenever
   // it is empty or being emptied in this cycle.
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;

   // Enhanced checksums start from the protected identifier, except for the
   // two diagnostic frames, which are always classic.
   assign pid_now = make_pid(cfg.frame_id);
   always_comb begin
      if (cfg.checksum_model == MODEL_CLASSIC || pid_now == PID_MASTER_REQUEST ||
          pid_now == PID_SLAVE_RESPONSE) begin
         seed = 8'h00;
      end else begin
         seed = pid_now;
      end
   end

   assign sum_cur = (pos_ff == '0) ? seed : sum_ff;

   // Add with end-around carry: a carry out of bit 7 comes back in at bit 0.
   assign sum_wide    = {1'b0, sum_cur} + {1'b0, req_chan.rx_byte};
   assign sum_wrapped = sum_wide[8] ? (sum_wide[7:0] + 8'd1) : sum_wide[7:0];

   assign echo_now = echo_failed_ff |
                     (req_chan.echo_check & (req_chan.rx_byte != req_chan.tx_byte));
   assign pos_wide = {1'b0, pos_ff};

   // A frame is too short if its checksum byte lands before the first data
   // position, and too long if it counts more than the configured bytes.
   assign length_bad = overrun_ff | (pos_ff < FIRST_DATA_POS) |
                       ((pos_wide + 5'd1) > MaxBytes);

   always_comb begin
      pos_in         = pos_ff;
      sum_in         = sum_ff;
      echo_failed_in = echo_failed_ff;
      overrun_in     = overrun_ff;
      if (accept) begin
         if (req_chan.last_byte) begin
            pos_in         = '0;
            sum_in         = '0;
            echo_failed_in = 1'b0;
            overrun_in     = 1'b0;
         end else begin
            sum_in         = (pos_ff >= FIRST_DATA_POS) ? sum_wrapped : sum_cur;
            echo_failed_in = echo_now;
            overrun_in     = overrun_ff | ((pos_wide + 5'd2) > MaxBytes);
            pos_in         = (pos_ff == LAST_POS) ? LAST_POS : (pos_ff + 4'd1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      status_in    = status_ff;
      pid_in       = pid_ff;
      expect_in    = expect_ff;
      if (accept && req_chan.last_byte) begin
         rsp_valid_in = 1'b1;
         pid_in       = pid_now;
         expect_in    = ~sum_cur;
         // Length trumps echo, and echo trumps the checksum comparison.
         priority if (length_bad) begin
            status_in = STATUS_LENGTH_ERROR;
         end else if (echo_now) begin
            status_in = STATUS_ECHO_ERROR;
         end else if (req_chan.rx_byte != ~sum_cur) begin
            status_in = STATUS_CHECKSUM_ERR;
         end else begin
            status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         sum_ff         <= '0;
         echo_failed_ff <= 1'b0;
         overrun_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         sum_ff         <= sum_in;
         echo_failed_ff <= echo_failed_in;
         overrun_ff     <= overrun_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      pid_ff    <= pid_in;
      expect_ff <= expect_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = status_ff;
   assign rsp_chan.protected_id      = pid_ff;
   assign rsp_chan.expected_checksum = expect_ff;

endmodule

### rtl/lfc_checker.sv
// Port-level assertions for the LIN frame checker, bound to its top level.
// Depends on lin_frame_checker_core and its channel interfaces.

module lfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_protected_id
);

   logic req_accept;

   assign req_accept = req_valid & req_ready;

   // A result word is held until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // The byte channel only stalls behind a stalled result word.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("byte channel stalled without a pending result");

   // A checksum byte yields a result word in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last_byte |=> rsp_valid)
      else $error("no result after the checksum byte");

   // Bytes other than the checksum byte never create a result word.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_last_byte && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("result word without a checksum byte");

   // Both parity bits of the reported identifier are consistent.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_protected_id[6] == (rsp_protected_id[0] ^ rsp_protected_id[1] ^
                                 rsp_protected_id[2] ^ rsp_protected_id[4]) &&
         rsp_protected_id[7] == !(rsp_protected_id[1] ^ rsp_protected_id[3] ^
                                  rsp_protected_id[4] ^ rsp_protected_id[5]))
      else $error("protected identifier parity wrong");

endmodule

bind lin_frame_checker_core lfc_checker u_lfc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last_byte    (req_chan.last_byte),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_protected_id (rsp_chan.protected_id)
);
